@@ rtl/core/tasp_pkg.sv @@
// ----------------------------------------------------------------------------
// tasp_pkg
// Shared types and constants of the three-axis step/direction generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tasp_pkg;

  localparam int NAXES     = 3;
  localparam int HP_W      = 19;
  localparam int POS_W     = 32;
  localparam int SPD_W     = 20;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 3;
  // holds |delta| * 1000 as well as the tick rate
  localparam int DIV_W     = 42;
  localparam int CNT_W     = 6;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;

  localparam logic [HP_W-1:0] HALF_MAX = 19'h7FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DIR_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MODE = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_MOVE    = 3'd1,
    CMD_SEGMENT = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_LIMIT   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_BUSY    = 3'd1,
    STS_BAD_MS  = 3'd2,
    STS_STOPPED = 3'd3,
    STS_BLOCKED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_AXIS,
    ST_DIV_SP,
    ST_DIV_HP,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/three_axis_step_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator
// Step/direction pulse generator for three stepper axes with one shared
// restoring divider for speed and half-period setup.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser: command, tdata: deltas, ms
//  m_axis    out  m_axis_tvalid/tready        tuser: status, tdata: lines, pos
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
//  tick, stop, limit and refused requests go from exec straight to the response.
//  a move visits the axis state per axis and runs one division per moving axis,
//  a segment up to two (second only on nonzero speed), one quotient bit a cycle.
//  no request is taken while one is at work or its result is not yet taken.
//  reset clears all axis state; config writes are taken in any cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_step_pulse_generator
  import tasp_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int AXIS_COUNT       = 3
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // delta_x, delta_y, delta_k, segment_ms
  input  wire [IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  wire [2:0]              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // step_lines, dir_lines, busy_mask, position_x, position_y, position_k,
  // limit_latched, zero fill
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [2:0]             m_axis_tuser,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [SPD_W-1:0]        cfg_data_i
);

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // configuration
  logic [NAXES-1:0] pdm_q;
  logic [SPD_W-1:0] spd_q [AXIS_COUNT];
  logic             cal_q;

  // axis state
  logic [HP_W-1:0]  tc_q    [AXIS_COUNT];
  logic [HP_W-1:0]  hp_q    [AXIS_COUNT];
  logic [POS_W-1:0] steps_q [AXIS_COUNT];
  logic [POS_W-1:0] pos_q   [AXIS_COUNT];
  logic             neg_q   [AXIS_COUNT];
  logic             lvl_q   [AXIS_COUNT];
  logic             dir_q   [AXIS_COUNT];
  logic             limit_q;

  // request
  cmd_e             cmd_q;
  logic [POS_W-1:0] dlt_q [AXIS_COUNT];
  logic [MS_W-1:0]  ms_q;
  status_e          sts_q, sts_d;

  state_e           state_q, state_d;
  logic [AW-1:0]    axis_q;

  // shared divider
  logic [DIV_W-1:0] rem_q, quo_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W:0]   rem_sh;
  logic             div_ge;
  logic [DIV_W-1:0] rem_nx, quo_nx;
  logic             div_last;

  logic             div_load, div_run, exec_upd, apply_axis, axis_clr, axis_inc;
  logic             resp_load, in_acc;
  logic [DIV_W-1:0] div_a, div_b;

  logic [POS_W-1:0] dsel, mag_sel;
  logic             neg_sel;
  logic [DIV_W-1:0] mag_ext, prod_ms;
  logic [DIV_W-1:0] hp_full;
  logic [HP_W-1:0]  hp_new;
  logic             any_busy, last_axis;

  logic [HP_W-1:0]  tc_inc [AXIS_COUNT];
  logic [NAXES-1:0] step_v, dir_v, busy_v;
  logic [POS_W-1:0] pos_out [NAXES];

  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rem_sh   = {rem_q, quo_q[DIV_W-1]};
    div_ge   = rem_sh >= {1'b0, dvs_q};
    rem_nx   = div_ge ? DIV_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_W-1:0];
    quo_nx   = {quo_q[DIV_W-2:0], div_ge};
    div_last = cnt_q == CNT_W'(DIV_W - 1);
  end

  always_comb begin
    dsel    = dlt_q[axis_q];
    neg_sel = dsel[POS_W-1];
    mag_sel = neg_sel ? (POS_W'(0) - dsel) : dsel;
    mag_ext = DIV_W'(mag_sel);
    // times 1000 as 1024 - 16 - 8
    prod_ms = (mag_ext << 10) - (mag_ext << 4) - (mag_ext << 3);
    hp_full = quo_nx >> 1;
    if (hp_full == '0) begin
      hp_new = HP_W'(1);
    end else if (hp_full > DIV_W'(HALF_MAX)) begin
      hp_new = HALF_MAX;
    end else begin
      hp_new = hp_full[HP_W-1:0];
    end
    last_axis = axis_q == AW'(AXIS_COUNT - 1);
  end

  always_comb begin
    any_busy = 1'b0;
    step_v   = '0;
    dir_v    = '0;
    busy_v   = '0;
    for (int a = 0; a < NAXES; a++) begin
      pos_out[a] = '0;
    end
    for (int a = 0; a < AXIS_COUNT; a++) begin
      tc_inc[a]  = tc_q[a] + HP_W'(1);
      step_v[a]  = lvl_q[a];
      dir_v[a]   = dir_q[a];
      busy_v[a]  = steps_q[a] != '0;
      pos_out[a] = pos_q[a];
      if (steps_q[a] != '0) begin
        any_busy = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    sts_d         = sts_q;
    s_axis_tready = 1'b0;
    div_load      = 1'b0;
    div_run       = 1'b0;
    div_a         = DIV_W'(TICKS_PER_SECOND);
    div_b         = '0;
    exec_upd      = 1'b0;
    apply_axis    = 1'b0;
    axis_clr      = 1'b0;
    axis_inc      = 1'b0;
    resp_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid || m_axis_tready;
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        exec_upd = 1'b1;
        axis_clr = 1'b1;
        sts_d    = STS_OK;
        state_d  = ST_RESP;
        case (cmd_q)
          CMD_STOP: sts_d = STS_STOPPED;
          CMD_LIMIT: begin
            if (!cal_q) begin
              sts_d = STS_STOPPED;
            end
          end
          CMD_MOVE: begin
            if (any_busy) begin
              sts_d = STS_BUSY;
            end else begin
              state_d = ST_AXIS;
            end
          end
          CMD_SEGMENT: begin
            if (limit_q) begin
              sts_d = STS_BLOCKED;
            end else if (ms_q == '0) begin
              sts_d = STS_BAD_MS;
            end else if (any_busy) begin
              sts_d = STS_BUSY;
            end else begin
              state_d = ST_AXIS;
            end
          end
          default: ;
        endcase
      end
      ST_AXIS: begin
        if (mag_sel == '0 || (cmd_q == CMD_MOVE && spd_q[axis_q] == '0)) begin
          axis_inc = !last_axis;
          state_d  = last_axis ? ST_RESP : ST_AXIS;
        end else if (cmd_q == CMD_MOVE) begin
          div_load = 1'b1;
          div_b    = DIV_W'(spd_q[axis_q]);
          state_d  = ST_DIV_HP;
        end else begin
          div_load = 1'b1;
          div_a    = prod_ms;
          div_b    = DIV_W'(ms_q);
          state_d  = ST_DIV_SP;
        end
      end
      ST_DIV_SP: begin
        div_run = 1'b1;
        if (div_last) begin
          if (quo_nx == '0) begin
            axis_inc = !last_axis;
            state_d  = last_axis ? ST_RESP : ST_AXIS;
          end else begin
            div_load = 1'b1;
            div_b    = quo_nx;
            state_d  = ST_DIV_HP;
          end
        end
      end
      ST_DIV_HP: begin
        div_run = 1'b1;
        if (div_last) begin
          apply_axis = 1'b1;
          axis_inc   = !last_axis;
          state_d    = last_axis ? ST_RESP : ST_AXIS;
        end
      end
      ST_RESP: begin
        resp_load = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdm_q         <= '1;
      cal_q         <= 1'b0;
      limit_q       <= 1'b0;
      cmd_q         <= CMD_TICK;
      sts_q         <= STS_OK;
      axis_q        <= '0;
      cnt_q         <= '0;
      m_axis_tvalid <= 1'b0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        spd_q[a]   <= SPD_W'(1000);
        tc_q[a]    <= '0;
        hp_q[a]    <= '0;
        steps_q[a] <= '0;
        pos_q[a]   <= '0;
        neg_q[a]   <= 1'b0;
        lvl_q[a]   <= 1'b0;
        dir_q[a]   <= 1'b0;
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_DIR_MASK) begin
          pdm_q <= cfg_data_i[NAXES-1:0];
        end
        if (cfg_index_i == CFG_CAL_MODE) begin
          cal_q <= cfg_data_i[0];
        end
        for (int a = 0; a < AXIS_COUNT; a++) begin
          if (cfg_index_i == CFG_IDX_W'(CFG_SPEED_X + CFG_IDX_W'(a))) begin
            spd_q[a] <= cfg_data_i;
          end
        end
      end

      if (in_acc) begin
        cmd_q <= cmd_e'(s_axis_tuser);
      end
      sts_q <= sts_d;

      if (div_load) begin
        cnt_q <= '0;
      end else if (div_run) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if (axis_clr) begin
        axis_q <= '0;
      end else if (axis_inc) begin
        axis_q <= axis_q + AW'(1);
      end

      if (exec_upd) begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
          if (cmd_q == CMD_TICK && steps_q[a] != '0) begin
            if (tc_inc[a] < hp_q[a]) begin
              tc_q[a] <= tc_inc[a];
            end else begin
              tc_q[a]  <= '0;
              lvl_q[a] <= !lvl_q[a];
              if (!lvl_q[a]) begin
                pos_q[a] <= neg_q[a] ? pos_q[a] - POS_W'(1) : pos_q[a] + POS_W'(1);
              end else begin
                steps_q[a] <= steps_q[a] - POS_W'(1);
              end
            end
          end
          if (cmd_q == CMD_STOP || (cmd_q == CMD_LIMIT && !cal_q)) begin
            steps_q[a] <= '0;
            lvl_q[a]   <= 1'b0;
            tc_q[a]    <= '0;
          end
        end
        if (cmd_q == CMD_LIMIT && !cal_q) begin
          limit_q <= 1'b1;
        end
      end

      if (apply_axis) begin
        hp_q[axis_q]    <= hp_new;
        neg_q[axis_q]   <= neg_sel;
        dir_q[axis_q]   <= pdm_q[axis_q] ^ neg_sel;
        steps_q[axis_q] <= mag_sel;
        tc_q[axis_q]    <= '0;
      end

      if (resp_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        dlt_q[a] <= s_axis_tdata[POS_W*a +: POS_W];
      end
      ms_q <= s_axis_tdata[NAXES*POS_W +: MS_W];
    end
    if (div_load) begin
      rem_q <= '0;
      quo_q <= div_a;
      dvs_q <= div_b;
    end else if (div_run) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
    if (resp_load) begin
      m_axis_tuser <= sts_q;
      m_axis_tdata <= {6'b0, limit_q, pos_out[2], pos_out[1], pos_out[0],
                       busy_v, dir_v, step_v};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tasp_checker.sv @@
// ----------------------------------------------------------------------------
// tasp_checker
// Port-level checks of the step/direction generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tasp_checker
  import tasp_pkg::*;
(
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tvalid,
  input wire                   s_axis_tready,
  input wire                   m_axis_tvalid,
  input wire                   m_axis_tready,
  input wire [OUT_DATA_W-1:0]  m_axis_tdata,
  input wire [2:0]             m_axis_tuser
);

  // result held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // a stop leaves every axis idle with step lines low
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STS_STOPPED |->
      m_axis_tdata[8:6] == 3'b000 && m_axis_tdata[2:0] == 3'b000)
    else $error("axis still running after stop");

  // busy refusal only when some axis has steps left
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STS_BUSY |-> m_axis_tdata[8:6] != 3'b000)
    else $error("busy status with no axis busy");

  // blocked segment only with the limit latched
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STS_BLOCKED |-> m_axis_tdata[105])
    else $error("blocked status without latched limit");

  // no new request while a result waits and is stalled
  a_serial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while result stalled");

endmodule

bind three_axis_step_pulse_generator tasp_checker u_tasp_checker (.*);

`default_nettype wire
